>>> src/bcht_pkg.sv
// Shared types and constants for the bucketed chained hash table.
package bcht_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned SIZE_W  = 64;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   ret_addr;
    logic [INDEX_W-1:0] entry_index;
    logic [SIZE_W-1:0]  frame_size;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
    logic [SIZE_W-1:0]  match_frame_size;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_BUCKET = 4'b0100,
    ST_WALK   = 4'b1000
  } state_e;

endpackage

>>> src/bcht_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module bcht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bucketed_chain_hash_table_core.sv
// Top level of the bucketed chained hash table: sequencer, bucket table and entry store.
//
// A request is taken when start is high and busy is low. An insert writes
// the key and stack size into the given entry slot, links that slot at the
// head of the bucket chosen by the return address, and gives no result. A
// lookup reads the bucket and then walks the chain through the entry store at
// one entry per cycle, comparing each stored key with the requested
// address, for at most as many entries as the bucket count says; the single
// entry-store read port sets that rate. The one result of a lookup is on
// rsp_o for exactly one cycle with rsp_valid_o high and cannot be held off
// by the receiver. Busy falls in the same cycle, so the next request may be
// taken while the result is shown. After reset the block stays busy while
// it clears the bucket counts, one bucket per cycle.
module bucketed_chain_hash_table_core
  import bcht_pkg::*;
#(
  parameter int unsigned BUCKETS = 32,
  parameter int unsigned ENTRIES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned SLOT_W = $clog2(ENTRIES);
  localparam int unsigned BRAM_W = COUNT_W + SLOT_W;
  localparam int unsigned ERAM_W = SLOT_W + SIZE_W + KEY_W;
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKETS - 1);

  state_e state_q, state_d;
  req_t   req_q;

  logic [BKT_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [SLOT_W-1:0]  cur_q, cur_d;
  logic [COUNT_W-1:0] rem_q, rem_d;

  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  // Bucket table port signals. Each word is {count, head slot}.
  logic              bkt_we, bkt_re;
  logic [BKT_W-1:0]  bkt_waddr, bkt_raddr;
  logic [BRAM_W-1:0] bkt_wdata, bkt_rdata;
  logic [COUNT_W-1:0] bkt_count;
  logic [SLOT_W-1:0]  bkt_head;

  // Entry store port signals. Each word is {link, stack size, key}.
  logic              ent_we, ent_re;
  logic [SLOT_W-1:0] ent_waddr, ent_raddr;
  logic [ERAM_W-1:0] ent_wdata, ent_rdata;
  logic [KEY_W-1:0]  ent_key;
  logic [SIZE_W-1:0] ent_size;
  logic [SLOT_W-1:0] ent_link;

  logic [BKT_W-1:0]  req_bucket, in_bucket;
  logic [SLOT_W-1:0] req_slot;
  logic [COUNT_W-1:0] count_inc;
  logic              key_hit;

  bcht_ram #(
    .WIDTH (BRAM_W),
    .DEPTH (BUCKETS),
    .AW    (BKT_W)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (bkt_re),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  bcht_ram #(
    .WIDTH (ERAM_W),
    .DEPTH (ENTRIES),
    .AW    (SLOT_W)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // The bucket is the address modulo the bucket count; for a power-of-two
  // count this is just the low address bits.
  assign in_bucket  = BKT_W'(req_i.ret_addr % 64'(BUCKETS));
  assign req_bucket = BKT_W'(req_q.ret_addr % 64'(BUCKETS));
  assign req_slot   = SLOT_W'(req_q.entry_index % ENTRIES);

  assign {bkt_count, bkt_head}          = bkt_rdata;
  assign {ent_link, ent_size, ent_key}  = ent_rdata;

  // The count saturates; further inserts still take over the head.
  assign count_inc = (bkt_count == COUNT_MAX) ? bkt_count : bkt_count + 1'b1;

  // The one shared comparator of the walk.
  assign key_hit = (ent_key == req_q.ret_addr);

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;

    bkt_we    = 1'b0;
    bkt_waddr = req_bucket;
    bkt_wdata = {count_inc, req_slot};
    bkt_re    = 1'b0;
    bkt_raddr = in_bucket;

    ent_we    = 1'b0;
    ent_waddr = req_slot;
    ent_wdata = {bkt_head, req_q.frame_size, req_q.ret_addr};
    ent_re    = 1'b0;
    ent_raddr = bkt_head;

    unique case (state_q)
      ST_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_cnt_q;
        bkt_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_BKT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // The bucket word is fetched for every incoming request.
        bkt_re = 1'b1;
        if (start) begin
          state_d = ST_BUCKET;
        end
      end
      ST_BUCKET: begin
        if (req_q.op == OP_INSERT) begin
          ent_we  = 1'b1;
          bkt_we  = 1'b1;
          state_d = ST_IDLE;
        end else if (bkt_count == '0) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '0;
          state_d     = ST_IDLE;
        end else begin
          ent_re  = 1'b1;
          cur_d   = bkt_head;
          rem_d   = bkt_count;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (key_hit) begin
          rsp_valid_d            = 1'b1;
          rsp_d.found            = 1'b1;
          rsp_d.match_index      = INDEX_W'(cur_q);
          rsp_d.match_frame_size = ent_size;
          state_d                = ST_IDLE;
        end else if (rem_q == COUNT_W'(1)) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '0;
          state_d     = ST_IDLE;
        end else begin
          // Follow the link to the next entry of the chain.
          ent_re    = 1'b1;
          ent_raddr = ent_link;
          cur_d     = ent_link;
          rem_d     = rem_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    cur_q <= cur_d;
    rem_q <= rem_d;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A result only ever follows a lookup.
  a_rsp_lookup_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (req_q.op == OP_LOOKUP))
    else $error("result issued for an insert request");

  // A result leaves from the bucket read or from the chain walk.
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ($past(state_q) == ST_BUCKET || $past(state_q) == ST_WALK))
    else $error("result issued outside the lookup sequence");

  // A miss reports zero index and zero stack size.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.found) |->
      (rsp_o.match_index == '0 && rsp_o.match_frame_size == '0))
    else $error("miss result carries nonzero payload");

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // The walk never runs past the bucket count.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (rem_q != '0))
    else $error("chain walk with no entries left");

endmodule

>>> dv/tb_bucketed_chain_hash_table_core.sv
// Self-checking testbench for the bucketed chained hash table core.
`timescale 1ns / 100ps

module tb_bucketed_chain_hash_table_core;
  import bcht_pkg::*;

  localparam int unsigned BUCKETS      = 32;
  localparam int unsigned ENTRIES      = 1024;
  localparam int unsigned BKT_W        = $clog2(BUCKETS);
  localparam int unsigned RANDOM_REQS  = 1333;
  // A lookup in a full bucket walks up to 2047 entries without any handshake.
  localparam int unsigned STALL_LIMIT  = 10000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 10;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic rsp_valid_o;
  rsp_t rsp_o;

  bucketed_chain_hash_table_core #(
    .BUCKETS(BUCKETS),
    .ENTRIES(ENTRIES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Requests waiting to be issued, and lookup responses still owed by the core.
  req_t pending_req_q [$];
  rsp_t expected_rsp_q [$];

  int unsigned req_count;
  int unsigned mismatch_cnt;
  int unsigned stall_cycles;

  // Shadow copy of the hash table. Entries that were never written read as
  // zero here; the stimulus makes sure the core never walks into one.
  bit [INDEX_W-1:0] tbl_head  [BUCKETS];
  bit [COUNT_W-1:0] tbl_count [BUCKETS];
  bit [KEY_W-1:0]   tbl_key   [ENTRIES];
  bit [SIZE_W-1:0]  tbl_size  [ENTRIES];
  bit [INDEX_W-1:0] tbl_link  [ENTRIES];

  // Applies one accepted request to the shadow table. A lookup walks the
  // chain from the bucket head for at most the bucket count and queues the
  // response it must produce; an insert relinks the slot at the head.
  function automatic void table_apply(req_t r);
    int unsigned bkt;
    int unsigned slot;
    int unsigned cur;
    rsp_t res;
    bkt = 32'(r.ret_addr % 64'(BUCKETS));
    if (r.op == OP_INSERT) begin
      slot = r.entry_index % ENTRIES;
      tbl_key[slot]  = r.ret_addr;
      tbl_size[slot] = r.frame_size;
      tbl_link[slot] = tbl_head[bkt];
      tbl_head[bkt]  = INDEX_W'(slot);
      if (tbl_count[bkt] < COUNT_MAX) tbl_count[bkt]++;
    end else begin
      res = '0;
      cur = 32'(tbl_head[bkt]);
      for (int unsigned i = 0; i < tbl_count[bkt]; i++) begin
        if (tbl_key[cur] == r.ret_addr) begin
          res.found            = 1'b1;
          res.match_index      = INDEX_W'(cur);
          res.match_frame_size = tbl_size[cur];
          break;
        end
        cur = tbl_link[cur] % ENTRIES;
      end
      expected_rsp_q.push_back(res);
    end
  endfunction

  // Bookkeeping for building requests. Each slot stays in the bucket it was
  // first inserted into; rewriting a slot inside its own bucket only forms a
  // cycle of written slots, whereas moving it to another bucket could splice
  // an unwritten link into some other chain.
  int               slot_home [ENTRIES];
  int unsigned      free_slot_q [$];
  int unsigned      used_slot_q [$];
  logic [KEY_W-1:0] known_key_q [$];

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_insert(logic [KEY_W-1:0] addr, int unsigned slot,
                              logic [SIZE_W-1:0] size);
    req_t r;
    r.op          = OP_INSERT;
    r.ret_addr    = addr;
    r.entry_index = INDEX_W'(slot);
    r.frame_size  = size;
    pending_req_q.push_back(r);
    if (slot_home[slot] < 0) begin
      slot_home[slot] = int'(addr % 64'(BUCKETS));
      used_slot_q.push_back(slot);
    end
    known_key_q.push_back(addr);
  endtask

  // Index and size fields are ignored on a lookup, so they carry noise.
  task automatic queue_lookup(logic [KEY_W-1:0] addr);
    req_t r;
    r.op          = OP_LOOKUP;
    r.ret_addr    = addr;
    r.entry_index = INDEX_W'($urandom());
    r.frame_size  = rand64();
    pending_req_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Request driver. A request that is shown but not yet taken is held; once
  // it is taken, the next one may be delayed by a random gap. Gaps are skipped
  // over one long stretch so that back-to-back requests are covered as well.
  always @(posedge clk_i) begin : drive_p
    logic present;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        table_apply(pending_req_q.pop_front());
        req_count++;
      end
      present = start && busy;
      if (!present && pending_req_q.size() != 0)
        present = (req_count >= 400 && req_count < 800) || $urandom_range(99) >= 33;
      start <= present;
      if (present) req <= pending_req_q[0];
    end
  end

  // Response checker. The core cannot be stalled, so every strobe is taken.
  always @(posedge clk_i) begin : check_p
    rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", '0, rsp_o.match_frame_size);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.found !== want.found)
          report_mismatch("found", want.found, rsp_o.found);
        if (rsp_o.match_index !== want.match_index)
          report_mismatch("match_index", want.match_index, rsp_o.match_index);
        if (rsp_o.match_frame_size !== want.match_frame_size)
          report_mismatch("match_frame_size", want.match_frame_size,
                          rsp_o.match_frame_size);
      end
    end
  end

  // Watchdog: any cycle without a taken request or a response counts.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || rsp_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stim_p
    int unsigned      pick;
    int unsigned      slot;
    int unsigned      roll;
    logic [KEY_W-1:0] addr;

    rst_ni       = 1'b0;
    start        = 1'b0;
    req          = '0;
    req_count    = 0;
    mismatch_cnt = 0;
    stall_cycles = 0;
    foreach (slot_home[i]) slot_home[i] = -1;

    // Directed part. Empty buckets first, then the extreme keys, slots and
    // sizes, a two-deep chain, a miss after a full walk, a duplicate key
    // (the newest entry must win) and a slot rewritten in its own bucket,
    // which turns the chain into a loop that hides the oldest entry.
    queue_lookup(64'h0);
    queue_lookup('1);
    queue_insert(64'h0, 0, 64'h0);
    queue_insert('1, ENTRIES - 1, '1);
    queue_lookup(64'h0);
    queue_lookup('1);
    queue_insert(64'h20, 5, rand64());
    queue_lookup(64'h20);
    queue_lookup(64'h0);
    queue_lookup(64'h40);
    queue_insert(64'h20, 6, rand64());
    queue_lookup(64'h20);
    queue_insert(64'h60, 5, rand64());
    queue_lookup(64'h20);
    queue_lookup(64'h0);
    queue_lookup(64'h60);
    queue_lookup('1);

    for (int unsigned s = 0; s < ENTRIES; s++)
      if (slot_home[s] < 0) free_slot_q.push_back(s);

    // Random part: mostly inserts of fresh slots and lookups of keys that are
    // in the table, so that chains grow long and walks end at every depth.
    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      roll = $urandom_range(99);
      if (roll < 40 && free_slot_q.size() != 0) begin
        pick = $urandom_range(free_slot_q.size() - 1);
        slot = free_slot_q[pick];
        free_slot_q.delete(pick);
        if ($urandom_range(4) == 0)
          addr = known_key_q[$urandom_range(known_key_q.size() - 1)];
        else
          addr = rand64();
        queue_insert(addr, slot, rand64());
      end else if (roll < 44) begin
        slot = used_slot_q[$urandom_range(used_slot_q.size() - 1)];
        addr = rand64();
        addr[BKT_W-1:0] = BKT_W'(slot_home[slot]);
        queue_insert(addr, slot, rand64());
      end else if (roll < 80) begin
        queue_lookup(known_key_q[$urandom_range(known_key_q.size() - 1)]);
      end else if (roll < 90) begin
        addr = rand64();
        addr[BKT_W-1:0] = BKT_W'(known_key_q[$urandom_range(known_key_q.size() - 1)]);
        queue_lookup(addr);
      end else begin
        queue_lookup(rand64());
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample on the falling edge so the queues are settled for the cycle.
    do @(negedge clk_i);
    while (pending_req_q.size() != 0 || start || expected_rsp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> bucketed_chain_hash_table_core.f
src/bcht_pkg.sv
src/bcht_ram.sv
src/bucketed_chain_hash_table_core.sv
dv/tb_bucketed_chain_hash_table_core.sv
